@@ hdl/text_line_glyph_renderer_unit_defines.svh @@
// ----------------------------------------------------------------------------
// text_line_glyph_renderer_unit_defines
// Assertion macros used by the glyph renderer top level.
// ----------------------------------------------------------------------------
`ifndef TEXT_LINE_GLYPH_RENDERER_UNIT_DEFINES_SVH
`define TEXT_LINE_GLYPH_RENDERER_UNIT_DEFINES_SVH

// checked only outside reset
`define TLGR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every edge, reset included
`define TLGR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hdl/tlgr_pkg.sv @@
// ----------------------------------------------------------------------------
// tlgr_pkg
// Constants, font table and controller/datapath interface types of the
// glyph renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package tlgr_pkg;

  localparam int MAX_WIDTH   = 128;
  localparam int MAX_HEIGHT  = 64;
  localparam int STORE_DEPTH = (MAX_WIDTH * MAX_HEIGHT) / 8;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int GLYPH_COLS  = 5;
  localparam int GLYPH_ROWS  = 7;
  localparam int FONT_SIZE   = 42;
  localparam int SLOT_W      = $clog2(FONT_SIZE);
  localparam int GCOL_W      = $clog2(GLYPH_COLS);

  localparam logic [SLOT_W-1:0] FALLBACK_SLOT = SLOT_W'(41);

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_PUT   = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef logic [GLYPH_COLS*GLYPH_ROWS-1:0] glyph_t;

  // column 0 in the top bits
  localparam glyph_t FONT_BITS [FONT_SIZE] = '{
    {7'h00, 7'h00, 7'h00, 7'h00, 7'h00}, {7'h08, 7'h08, 7'h08, 7'h08, 7'h08},
    {7'h00, 7'h00, 7'h00, 7'h06, 7'h06}, {7'h00, 7'h36, 7'h36, 7'h00, 7'h00},
    {7'h03, 7'h06, 7'h0C, 7'h18, 7'h30},
    {7'h3E, 7'h45, 7'h49, 7'h51, 7'h3E}, {7'h00, 7'h21, 7'h7F, 7'h01, 7'h00},
    {7'h21, 7'h43, 7'h45, 7'h49, 7'h31}, {7'h42, 7'h41, 7'h51, 7'h69, 7'h46},
    {7'h0C, 7'h14, 7'h24, 7'h7F, 7'h04}, {7'h72, 7'h51, 7'h51, 7'h51, 7'h4E},
    {7'h1E, 7'h29, 7'h49, 7'h49, 7'h06}, {7'h40, 7'h47, 7'h48, 7'h50, 7'h60},
    {7'h36, 7'h49, 7'h49, 7'h49, 7'h36}, {7'h30, 7'h49, 7'h49, 7'h4A, 7'h3C},
    {7'h1F, 7'h24, 7'h44, 7'h24, 7'h1F}, {7'h7F, 7'h49, 7'h49, 7'h49, 7'h36},
    {7'h3E, 7'h41, 7'h41, 7'h41, 7'h22}, {7'h7F, 7'h41, 7'h41, 7'h22, 7'h1C},
    {7'h7F, 7'h49, 7'h49, 7'h49, 7'h41}, {7'h7F, 7'h48, 7'h48, 7'h48, 7'h40},
    {7'h3E, 7'h41, 7'h49, 7'h49, 7'h2E}, {7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F},
    {7'h00, 7'h41, 7'h7F, 7'h41, 7'h00}, {7'h02, 7'h01, 7'h01, 7'h01, 7'h7E},
    {7'h7F, 7'h08, 7'h14, 7'h22, 7'h41}, {7'h7F, 7'h01, 7'h01, 7'h01, 7'h01},
    {7'h7F, 7'h20, 7'h10, 7'h20, 7'h7F}, {7'h7F, 7'h10, 7'h08, 7'h04, 7'h7F},
    {7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E}, {7'h7F, 7'h48, 7'h48, 7'h48, 7'h30},
    {7'h3E, 7'h41, 7'h45, 7'h42, 7'h3D}, {7'h7F, 7'h48, 7'h4C, 7'h4A, 7'h31},
    {7'h32, 7'h49, 7'h49, 7'h49, 7'h26}, {7'h40, 7'h40, 7'h7F, 7'h40, 7'h40},
    {7'h7E, 7'h01, 7'h01, 7'h01, 7'h7E}, {7'h7C, 7'h02, 7'h01, 7'h02, 7'h7C},
    {7'h7E, 7'h01, 7'h06, 7'h01, 7'h7E}, {7'h63, 7'h14, 7'h08, 7'h14, 7'h63},
    {7'h70, 7'h08, 7'h07, 7'h08, 7'h70}, {7'h43, 7'h45, 7'h49, 7'h51, 7'h61},
    {7'h20, 7'h40, 7'h4D, 7'h50, 7'h20}
  };

  typedef struct packed {
    logic load;
    logic setup;
    logic wipe;
    logic draw;
    logic fetch;
    logic finish;
  } tlgr_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       reject;
    logic       col_last;
    logic       addr_last;
    logic       out_free;
  } tlgr_stat_t;

  // upper-case fold, then font slot; anything unknown draws as '?'
  function automatic logic [SLOT_W-1:0] glyph_slot(input logic [7:0] code);
    logic [7:0]        c;
    logic [SLOT_W-1:0] s;
    c = code;
    if (c >= 8'h61 && c <= 8'h7A) c = c - 8'h20;
    s = FALLBACK_SLOT;
    if (c == 8'h20) s = SLOT_W'(0);
    else if (c == 8'h2D) s = SLOT_W'(1);
    else if (c == 8'h2E) s = SLOT_W'(2);
    else if (c == 8'h3A) s = SLOT_W'(3);
    else if (c == 8'h2F) s = SLOT_W'(4);
    else if (c >= 8'h30 && c <= 8'h39) s = SLOT_W'(c - 8'h30 + 8'd5);
    else if (c >= 8'h41 && c <= 8'h5A) s = SLOT_W'(c - 8'h41 + 8'd15);
    return s;
  endfunction

endpackage

`default_nettype wire

@@ hdl/text_line_glyph_renderer_unit.sv @@
// ----------------------------------------------------------------------------
// text_line_glyph_renderer_unit
// 5x7 text renderer into a page-layout 1024-byte frame store.
// ----------------------------------------------------------------------------
// After reset the store is wiped one byte per cycle with in_stall high;
// configuration writes are taken throughout. Items are handled one at a
// time by a sequencer around the single-port store: put character makes
// one store write per glyph column and clear makes one write per store
// byte. A new item is taken while the last result still waits on out_stall.
`default_nettype none

`include "text_line_glyph_renderer_unit_defines.svh"

module text_line_glyph_renderer_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic                        cfg_index,
  input  wire logic [7:0]                  cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  command,
  input  wire logic [2:0]                  line_index,
  input  wire logic [4:0]                  column_index,
  input  wire logic [7:0]                  char_code,
  input  wire logic [tlgr_pkg::ADDR_W-1:0] byte_index,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [7:0]                  read_data,
  output logic                             status
);

  import tlgr_pkg::*;

  tlgr_cmd_t  ctl;
  tlgr_stat_t stat;

  assign cfg_ready = 1'b1;

  tlgr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .ctl     (ctl)
  );

  tlgr_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid & cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .command     (command),
    .line_index  (line_index),
    .column_index(column_index),
    .char_code   (char_code),
    .byte_index  (byte_index),
    .ctl         (ctl),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_data   (read_data),
    .status      (status)
  );

  `TLGR_ASSERT(a_busy_after_transfer, (in_valid && !in_stall) |=> in_stall, "taken item did not stall input")
  `TLGR_ASSERT(a_finish_loads_result, ctl.finish |=> out_valid, "finished item left no result")
  `TLGR_ASSERT_ALWAYS(a_wipe_after_reset, rst |=> in_stall, "input open before store wipe")

endmodule

`default_nettype wire

@@ hdl/tlgr_ram.sv @@
// ----------------------------------------------------------------------------
// tlgr_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tlgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) mem[addr] <= wdata;
      else rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/tlgr_ctrl.sv @@
// ----------------------------------------------------------------------------
// tlgr_ctrl
// Sequencer: store wipe after reset, command decode, glyph column writes,
// byte fetch and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tlgr_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire tlgr_pkg::tlgr_stat_t stat,
  output tlgr_pkg::tlgr_cmd_t     ctl
);

  import tlgr_pkg::*;

  typedef enum logic [6:0] {
    S_INIT   = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_DECODE = 7'b0000100,
    S_WIPE   = 7'b0001000,
    S_DRAW   = 7'b0010000,
    S_FETCH  = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_INIT;
    else state <= state_next;
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_INIT: begin
        ctl.wipe = 1'b1;
        if (stat.addr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        ctl.load = in_valid;
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        ctl.setup = 1'b1;
        if (stat.reject) state_next = S_FINISH;
        else if (stat.cmd == CMD_CLEAR) state_next = S_WIPE;
        else if (stat.cmd == CMD_PUT) state_next = S_DRAW;
        else if (stat.cmd == CMD_READ) state_next = S_FETCH;
        else state_next = S_FINISH;
      end
      S_WIPE: begin
        ctl.wipe = 1'b1;
        if (stat.addr_last) state_next = S_FINISH;
      end
      S_DRAW: begin
        ctl.draw = 1'b1;
        if (stat.col_last) state_next = S_FINISH;
      end
      S_FETCH: begin
        ctl.fetch  = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        ctl.finish = stat.out_free;
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_INIT;
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/tlgr_datapath.sv @@
// ----------------------------------------------------------------------------
// tlgr_datapath
// Panel registers, range checks, store address generation, frame store and
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tlgr_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  input  wire logic                        cfg_index,
  input  wire logic [7:0]                  cfg_data,
  input  wire logic [1:0]                  command,
  input  wire logic [2:0]                  line_index,
  input  wire logic [4:0]                  column_index,
  input  wire logic [7:0]                  char_code,
  input  wire logic [tlgr_pkg::ADDR_W-1:0] byte_index,
  input  wire tlgr_pkg::tlgr_cmd_t         ctl,
  output tlgr_pkg::tlgr_stat_t             stat,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [7:0]                  read_data,
  output logic                             status
);

  import tlgr_pkg::*;

  logic [7:0]        panel_width;
  logic [6:0]        panel_height;
  logic [1:0]        cmd_q;
  logic [2:0]        line_q;
  logic [4:0]        col_q;
  logic [SLOT_W-1:0] slot_q;
  logic [ADDR_W-1:0] byte_q;
  logic [ADDR_W-1:0] addr;
  logic [GCOL_W-1:0] gcol;

  logic [7:0]        w_clamp, w_eff;
  logic [6:0]        h_eff;
  logic [8:0]        cell_x;
  logic [14:0]       area;
  logic [10:0]       line_off;
  logic [10:0]       base;
  logic              line_bad, col_bad, rd_bad, reject;
  glyph_t            glyph;
  logic [GLYPH_ROWS-1:0] glyph_col;
  logic              mem_en, mem_we;
  logic [7:0]        mem_wdata, mem_rdata;
  logic              out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      panel_width  <= 8'(MAX_WIDTH);
      panel_height <= 7'(MAX_HEIGHT);
    end else if (cfg_valid) begin
      if (cfg_index == REG_WIDTH) panel_width <= cfg_data;
      else if (cfg_index == REG_HEIGHT) panel_height <= cfg_data[6:0];
    end
  end

  always_comb begin
    if (panel_width < 8'd8) w_clamp = 8'd8;
    else if (panel_width > 8'(MAX_WIDTH)) w_clamp = 8'(MAX_WIDTH);
    else w_clamp = panel_width;
    w_eff = {w_clamp[7:3], 3'b000};
    if (panel_height < 7'd8) h_eff = 7'd8;
    else if (panel_height > 7'(MAX_HEIGHT)) h_eff = 7'(MAX_HEIGHT);
    else h_eff = panel_height;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q  <= command;
      line_q <= line_index;
      col_q  <= column_index;
      slot_q <= glyph_slot(char_code);
      byte_q <= byte_index;
    end
  end

  // cell x = column * 6; column fits iff x + 6 <= width
  assign cell_x   = {2'b00, col_q, 2'b00} + {3'b000, col_q, 1'b0};
  assign col_bad  = (cell_x + 9'd6) > {1'b0, w_eff};
  assign line_bad = {1'b0, line_q} >= h_eff[6:3];
  assign area     = 15'(w_eff) * 15'(h_eff);
  assign rd_bad   = 12'(byte_q) >= area[14:3];
  assign line_off = 11'(line_q) * 11'(w_eff);
  assign base     = line_off + {2'b00, cell_x};

  always_comb begin
    case (cmd_q)
      CMD_CLEAR: reject = 1'b0;
      CMD_PUT:   reject = line_bad | col_bad;
      CMD_READ:  reject = rd_bad;
      default:   reject = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
      gcol <= '0;
    end else if (ctl.setup) begin
      gcol <= '0;
      if (cmd_q == CMD_CLEAR) addr <= '0;
      else if (cmd_q == CMD_PUT) addr <= base[ADDR_W-1:0];
      else addr <= byte_q;
    end else if (ctl.wipe || ctl.draw) begin
      addr <= addr + 1'b1;
      if (ctl.draw) gcol <= gcol + 1'b1;
    end
  end

  // bit 7 is never set by any write, so a glyph write needs no old byte
  assign glyph     = FONT_BITS[slot_q];
  assign glyph_col = glyph[(GLYPH_COLS-1-32'(gcol))*GLYPH_ROWS +: GLYPH_ROWS];
  assign mem_en    = ctl.wipe | ctl.draw | ctl.fetch;
  assign mem_we    = ctl.wipe | ctl.draw;
  assign mem_wdata = ctl.draw ? {1'b0, glyph_col} : 8'h00;

  tlgr_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .en   (mem_en),
    .we   (mem_we),
    .addr (addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (ctl.finish) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      read_data <= (cmd_q == CMD_READ && !reject) ? mem_rdata : 8'h00;
      status    <= reject;
    end
  end

  assign stat.cmd       = cmd_q;
  assign stat.reject    = reject;
  assign stat.col_last  = (gcol == GCOL_W'(GLYPH_COLS - 1));
  assign stat.addr_last = (addr == ADDR_W'(STORE_DEPTH - 1));
  assign stat.out_free  = out_free;

endmodule

`default_nettype wire

@@ tb/sv/text_line_glyph_renderer_unit_checker.sv @@
// ----------------------------------------------------------------------------
// text_line_glyph_renderer_unit_checker
// Watches the config, command and result channels of the glyph renderer. It
// keeps its own copy of the frame store and panel size, works out the
// response of every accepted command, and compares it field by field with
// the results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_line_glyph_renderer_unit_checker (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  input  wire logic                        cfg_ready,
  input  wire logic                        cfg_index,
  input  wire logic [7:0]                  cfg_data,
  input  wire logic                        in_valid,
  input  wire logic                        in_stall,
  input  wire logic [1:0]                  command,
  input  wire logic [2:0]                  line_index,
  input  wire logic [4:0]                  column_index,
  input  wire logic [7:0]                  char_code,
  input  wire logic [tlgr_pkg::ADDR_W-1:0] byte_index,
  input  wire logic                        out_valid,
  input  wire logic                        out_stall,
  input  wire logic [7:0]                  read_data,
  input  wire logic                        status,
  output int                               error_count,
  output int                               outstanding
);

  import tlgr_pkg::*;

  localparam int CELL_W      = 6;
  localparam int LINE_H      = 8;
  localparam int QMARK_SLOT  = FONT_SIZE - 1;
  localparam int MIN_DIM     = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       status;
  } glyph_result_t;

  glyph_result_t expected_results[$];
  logic [7:0]    pixel_store [STORE_DEPTH];
  logic [7:0]    width_reg;
  logic [6:0]    height_reg;
  logic [7:0]    glyph_codes [FONT_SIZE];
  logic [7:0]    glyph_rom [FONT_SIZE*GLYPH_COLS];
  int            errors = 0;

  initial begin
    glyph_codes = '{
      8'h20, 8'h2D, 8'h2E, 8'h3A, 8'h2F,
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
      8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4A,
      8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54,
      8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A, 8'h3F
    };
    glyph_rom = '{
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00,  8'h08, 8'h08, 8'h08, 8'h08, 8'h08,
      8'h00, 8'h00, 8'h00, 8'h06, 8'h06,  8'h00, 8'h36, 8'h36, 8'h00, 8'h00,
      8'h03, 8'h06, 8'h0C, 8'h18, 8'h30,
      8'h3E, 8'h45, 8'h49, 8'h51, 8'h3E,  8'h00, 8'h21, 8'h7F, 8'h01, 8'h00,
      8'h21, 8'h43, 8'h45, 8'h49, 8'h31,  8'h42, 8'h41, 8'h51, 8'h69, 8'h46,
      8'h0C, 8'h14, 8'h24, 8'h7F, 8'h04,  8'h72, 8'h51, 8'h51, 8'h51, 8'h4E,
      8'h1E, 8'h29, 8'h49, 8'h49, 8'h06,  8'h40, 8'h47, 8'h48, 8'h50, 8'h60,
      8'h36, 8'h49, 8'h49, 8'h49, 8'h36,  8'h30, 8'h49, 8'h49, 8'h4A, 8'h3C,
      8'h1F, 8'h24, 8'h44, 8'h24, 8'h1F,  8'h7F, 8'h49, 8'h49, 8'h49, 8'h36,
      8'h3E, 8'h41, 8'h41, 8'h41, 8'h22,  8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C,
      8'h7F, 8'h49, 8'h49, 8'h49, 8'h41,  8'h7F, 8'h48, 8'h48, 8'h48, 8'h40,
      8'h3E, 8'h41, 8'h49, 8'h49, 8'h2E,  8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F,
      8'h00, 8'h41, 8'h7F, 8'h41, 8'h00,  8'h02, 8'h01, 8'h01, 8'h01, 8'h7E,
      8'h7F, 8'h08, 8'h14, 8'h22, 8'h41,  8'h7F, 8'h01, 8'h01, 8'h01, 8'h01,
      8'h7F, 8'h20, 8'h10, 8'h20, 8'h7F,  8'h7F, 8'h10, 8'h08, 8'h04, 8'h7F,
      8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E,  8'h7F, 8'h48, 8'h48, 8'h48, 8'h30,
      8'h3E, 8'h41, 8'h45, 8'h42, 8'h3D,  8'h7F, 8'h48, 8'h4C, 8'h4A, 8'h31,
      8'h32, 8'h49, 8'h49, 8'h49, 8'h26,  8'h40, 8'h40, 8'h7F, 8'h40, 8'h40,
      8'h7E, 8'h01, 8'h01, 8'h01, 8'h7E,  8'h7C, 8'h02, 8'h01, 8'h02, 8'h7C,
      8'h7E, 8'h01, 8'h06, 8'h01, 8'h7E,  8'h63, 8'h14, 8'h08, 8'h14, 8'h63,
      8'h70, 8'h08, 8'h07, 8'h08, 8'h70,  8'h43, 8'h45, 8'h49, 8'h51, 8'h61,
      8'h20, 8'h40, 8'h4D, 8'h50, 8'h20
    };
  end

  function automatic int panel_cols_px();
    int w;
    w = width_reg;
    if (w < MIN_DIM) w = MIN_DIM;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w & ~7;
  endfunction

  function automatic int panel_rows_px();
    int h;
    h = height_reg;
    if (h < MIN_DIM) h = MIN_DIM;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    return h;
  endfunction

  function automatic int font_index(input logic [7:0] raw);
    logic [7:0] folded;
    folded = raw;
    if (folded >= 8'h61 && folded <= 8'h7A) folded = folded - 8'h20;
    for (int k = 0; k < FONT_SIZE; k++) begin
      if (glyph_codes[k] == folded) return k;
    end
    return QMARK_SLOT;
  endfunction

  // updates the store copy and queues the response of one command transfer
  task automatic render_command(input logic [1:0] cmd, input logic [2:0] line,
                                input logic [4:0] col, input logic [7:0] code,
                                input logic [ADDR_W-1:0] addr);
    int            w;
    int            h;
    int            base;
    int            slot;
    glyph_result_t r;
    w = panel_cols_px();
    h = panel_rows_px();
    r = '0;
    case (cmd)
      CMD_CLEAR: begin
        foreach (pixel_store[i]) pixel_store[i] = '0;
      end
      CMD_PUT: begin
        if (int'(line) >= h / LINE_H || int'(col) >= w / CELL_W) begin
          r.status = 1'b1;
        end else begin
          slot = font_index(code);
          base = int'(col) * CELL_W + int'(line) * w;
          for (int c = 0; c < GLYPH_COLS; c++) begin
            if (base + c < STORE_DEPTH)
              pixel_store[base+c] = {pixel_store[base+c][7],
                                     glyph_rom[slot*GLYPH_COLS+c][6:0]};
          end
        end
      end
      CMD_READ: begin
        if (int'(addr) >= (w * h) / LINE_H) r.status = 1'b1;
        else r.data = pixel_store[addr];
      end
      default: r.status = 1'b1;
    endcase
    expected_results.push_back(r);
  endtask

  always @(posedge clk) begin
    glyph_result_t want;
    if (rst) begin
      expected_results.delete();
      foreach (pixel_store[i]) pixel_store[i] = '0;
      width_reg  = 8'd128;
      height_reg = 7'd64;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_WIDTH) width_reg = cfg_data;
        else height_reg = cfg_data[6:0];
      end
      if (in_valid && !in_stall)
        render_command(command, line_index, column_index, char_code, byte_index);
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected: read_data %02h status %0d",
                   $time, read_data, status);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (read_data !== want.data) begin
            $display("%0t: read_data expected %02h actual %02h",
                     $time, want.data, read_data);
            errors++;
          end
          if (status !== want.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, status);
            errors++;
          end
        end
      end
    end
    error_count <= errors;
    outstanding <= expected_results.size();
  end

endmodule

@@ tb/sv/text_line_glyph_renderer_unit_tb.sv @@
// ----------------------------------------------------------------------------
// text_line_glyph_renderer_unit_tb
// Drives the glyph renderer with a directed set of put, read, clear and
// unused-code commands, then random command streams over a series of panel
// sizes including the clamped extremes. Both channels idle at random. The
// checker module predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_line_glyph_renderer_unit_tb;
  import tlgr_pkg::*;

  localparam logic [1:0] CMD_SPARE   = 2'd3;
  localparam int         CYCLE_LIMIT = 1_000_000;
  localparam int         N_PANELS    = 8;
  localparam int         PER_PANEL   = 75;
  localparam int         DRAIN       = 40;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              cfg_valid    = 1'b0;
  logic              cfg_index    = REG_WIDTH;
  logic [7:0]        cfg_data     = '0;
  logic              in_valid     = 1'b0;
  logic [1:0]        command      = CMD_CLEAR;
  logic [2:0]        line_index   = '0;
  logic [4:0]        column_index = '0;
  logic [7:0]        char_code    = '0;
  logic [ADDR_W-1:0] byte_index   = '0;
  logic              out_stall    = 1'b0;
  logic              cfg_ready;
  logic              in_stall;
  logic              out_valid;
  logic [7:0]        read_data;
  logic              status;

  int error_count;
  int outstanding;
  int cycles     = 0;
  bit stalls_on  = 1'b1;
  bit gaps_on    = 1'b1;
  int stall_left = 0;
  int free_left  = 0;
  int n_put      = 0;
  int n_read     = 0;
  int n_clear    = 0;
  int n_spare    = 0;

  // raw register values, then the panel size they should take effect as
  int raw_w [N_PANELS] = '{128, 8, 255, 0, 100, 127, 47, 64};
  int raw_h [N_PANELS] = '{64, 8, 127, 0, 40, 63, 17, 32};
  int eff_w [N_PANELS] = '{128, 8, 128, 8, 96, 120, 40, 64};
  int eff_h [N_PANELS] = '{64, 8, 64, 8, 40, 63, 17, 32};

  text_line_glyph_renderer_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .line_index   (line_index),
    .column_index (column_index),
    .char_code    (char_code),
    .byte_index   (byte_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .read_data    (read_data),
    .status       (status)
  );

  text_line_glyph_renderer_unit_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .line_index   (line_index),
    .column_index (column_index),
    .char_code    (char_code),
    .byte_index   (byte_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .read_data    (read_data),
    .status       (status),
    .error_count  (error_count),
    .outstanding  (outstanding)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (!stalls_on) begin
      out_stall <= 1'b0;
    end else if (out_stall) begin
      if (stall_left > 0) stall_left--;
      else begin
        out_stall <= 1'b0;
        free_left = pick_gap();
      end
    end else begin
      if (free_left > 0) free_left--;
      else begin
        out_stall <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'h41 + 8'($urandom_range(0, 25));
      3, 4:    return 8'h61 + 8'($urandom_range(0, 25));
      5, 6:    return 8'h30 + 8'($urandom_range(0, 9));
      7: begin
        case ($urandom_range(0, 5))
          0:       return 8'h20;
          1:       return 8'h2D;
          2:       return 8'h2E;
          3:       return 8'h3A;
          4:       return 8'h2F;
          default: return 8'h3F;
        endcase
      end
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic [1:0] cmd, input logic [2:0] line,
                           input logic [4:0] col, input logic [7:0] code,
                           input logic [ADDR_W-1:0] addr);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    line_index   <= line;
    column_index <= col;
    char_code    <= code;
    byte_index   <= addr;
    do @(posedge clk); while (in_stall);
    case (cmd)
      CMD_CLEAR: n_clear++;
      CMD_PUT:   n_put++;
      CMD_READ:  n_read++;
      default:   n_spare++;
    endcase
  endtask

  // sender holds off until every expected result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_panel(input int w, input int h);
    write_reg(REG_WIDTH, 8'(w));
    write_reg(REG_HEIGHT, 8'(h));
    cfg_valid <= 1'b0;
  endtask

  task automatic random_item(input int w, input int h);
    int                lines;
    int                cols;
    int                frame;
    int                sel;
    logic [1:0]        cmd;
    logic [2:0]        line;
    logic [4:0]        col;
    logic [7:0]        code;
    logic [ADDR_W-1:0] addr;
    lines = h / 8;
    cols  = w / 6;
    frame = (w * h) / 8;
    line  = 3'($urandom);
    col   = 5'($urandom);
    code  = 8'($urandom);
    addr  = ADDR_W'($urandom);
    sel   = $urandom_range(0, 99);
    if (sel < 50) begin
      cmd = CMD_PUT;
      if ($urandom_range(0, 9) < 8) begin
        line = 3'($urandom_range(0, lines - 1));
        col  = 5'($urandom_range(0, cols - 1));
      end
      code = pick_char();
    end else if (sel < 93) begin
      cmd = CMD_READ;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: addr = ADDR_W'($urandom_range(0, lines - 1) * w +
                                   $urandom_range(0, cols - 1) * 6 +
                                   $urandom_range(0, 5));
        4, 5, 6:    addr = ADDR_W'($urandom_range(0, frame - 1));
        7:          addr = ADDR_W'(frame - 1 + $urandom_range(0, 1));
        default:    ;
      endcase
    end else if (sel < 96) begin
      cmd = CMD_CLEAR;
    end else begin
      cmd = CMD_SPARE;
    end
    send_item(cmd, line, col, code, addr);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset panel size of 128 x 64
    send_item(CMD_READ,  3'd0, 5'd0,  8'h00, ADDR_W'(0));
    send_item(CMD_PUT,   3'd0, 5'd0,  8'h41, ADDR_W'(0));
    send_item(CMD_READ,  3'd0, 5'd0,  8'h00, ADDR_W'(0));
    send_item(CMD_READ,  3'd0, 5'd0,  8'h00, ADDR_W'(4));
    send_item(CMD_READ,  3'd0, 5'd0,  8'h00, ADDR_W'(5));
    send_item(CMD_PUT,   3'd7, 5'd20, 8'h7A, ADDR_W'(0));
    send_item(CMD_READ,  3'd0, 5'd0,  8'h00, ADDR_W'(1020));
    send_item(CMD_READ,  3'd7, 5'd31, 8'hFF, ADDR_W'(1023));
    send_item(CMD_PUT,   3'd0, 5'd21, 8'h31, ADDR_W'(0));
    send_item(CMD_PUT,   3'd0, 5'd31, 8'h31, ADDR_W'(0));
    send_item(CMD_PUT,   3'd0, 5'd1,  8'h00, ADDR_W'(0));
    send_item(CMD_PUT,   3'd0, 5'd2,  8'hFF, ADDR_W'(0));
    send_item(CMD_PUT,   3'd0, 5'd3,  8'h7B, ADDR_W'(0));
    send_item(CMD_PUT,   3'd0, 5'd4,  8'h60, ADDR_W'(0));
    send_item(CMD_PUT,   3'd0, 5'd5,  8'h40, ADDR_W'(0));
    send_item(CMD_PUT,   3'd0, 5'd6,  8'h5B, ADDR_W'(0));
    send_item(CMD_PUT,   3'd1, 5'd0,  8'h3F, ADDR_W'(0));
    send_item(CMD_READ,  3'd0, 5'd0,  8'h00, ADDR_W'(7));
    send_item(CMD_READ,  3'd0, 5'd0,  8'h00, ADDR_W'(130));
    send_item(CMD_SPARE, 3'd7, 5'd31, 8'hFF, ADDR_W'(1023));
    send_item(CMD_SPARE, 3'd0, 5'd0,  8'h00, ADDR_W'(0));
    send_item(CMD_CLEAR, 3'd7, 5'd31, 8'hFF, ADDR_W'(1023));
    send_item(CMD_READ,  3'd0, 5'd0,  8'h00, ADDR_W'(1020));
    send_item(CMD_READ,  3'd0, 5'd0,  8'h00, ADDR_W'(6));

    for (int p = 0; p < N_PANELS; p++) begin
      drain_results();
      set_panel(raw_w[p], raw_h[p]);
      stalls_on <= (p != N_PANELS - 2);
      gaps_on   <= (p != N_PANELS - 2);
      repeat (PER_PANEL) random_item(eff_w[p], eff_h[p]);
    end

    drain_results();
    repeat (DRAIN) @(posedge clk);

    $display("Sent %0d puts, %0d reads, %0d clears and %0d unused-code commands",
             n_put, n_read, n_clear, n_spare);
    $display("over %0d panel sizes, clamped extremes included", N_PANELS);
    if (error_count == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", error_count, outstanding);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
